/* src/streaming_nfa_pattern_matcher_top_macros.svh */
`ifndef STREAMING_NFA_PATTERN_MATCHER_TOP_MACROS_SVH
`define STREAMING_NFA_PATTERN_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SNPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SNPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/snpm_pkg.sv */
package snpm_pkg;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned MASK_W = 16;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [IDX_W-1:0] {
    REG_LIT_LO = 3'd0,
    REG_LIT_HI = 3'd1,
    REG_ANY = 3'd2,
    REG_NONSPACE = 3'd3,
    REG_REPEAT = 3'd4,
    REG_COUNT = 3'd5,
    REG_ICASE = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    FUNC_CONSUME = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  // Per-atom configuration seen by one cell.
  typedef struct packed {
    logic [7:0] lit;
    logic       any;
    logic       nonspace;
    logic       rep;
  } snpm_atom_t;

  // Signals handed combinationally from one cell to the next.
  typedef struct packed {
    logic cur_carry;
    logic nxt_carry;
  } snpm_link_t;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic is_low;
    is_low = (b >= CH_LOW_A) && (b <= CH_LOW_Z);
    return is_low ? (b - CASE_OFS) : b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_NUL) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
           (b == CH_SPACE);
  endfunction

endpackage

/* src/streaming_nfa_pattern_matcher_top.sv */
// Unanchored pattern search over a byte stream, one byte per clock. Each
// input transfer either consumes a byte or restarts the search, and yields
// one registered result transfer carrying the sticky matched flag. The
// active-state vector lives in a chain of one cell per atom; both repeat
// closures and the byte test ripple combinationally through that chain, so
// its length sets the clock rate, not the throughput. A two-entry output
// buffer keeps the input open while one result waits; the input stalls only
// when both entries are full. The user must write configuration through the
// plain write port while no transfer is in flight; the block does not check.
`include "streaming_nfa_pattern_matcher_top_macros.svh"

module streaming_nfa_pattern_matcher_top import snpm_pkg::*; #(
  parameter int unsigned MAX_ATOMS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             matched_o
);

  logic [CFG_W-1:0]  lit_lo_q, lit_hi_q;
  logic [MASK_W-1:0] any_q, nonspace_q, repeat_q;
  logic [CNT_W-1:0]  count_q;
  logic              icase_q;

  logic match_q, match_d;
  logic [CNT_W-1:0] n;
  logic accept, upd, clr, accept_hit, result;
  logic [MAX_ATOMS-1:0] acc, state;
  snpm_link_t link [MAX_ATOMS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_lo_q <= '0;
      lit_hi_q <= '0;
      any_q <= '0;
      nonspace_q <= '0;
      repeat_q <= '0;
      count_q <= '0;
      icase_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LIT_LO: lit_lo_q <= cfg_data_i;
        REG_LIT_HI: lit_hi_q <= cfg_data_i;
        REG_ANY: any_q <= cfg_data_i[MASK_W-1:0];
        REG_NONSPACE: nonspace_q <= cfg_data_i[MASK_W-1:0];
        REG_REPEAT: repeat_q <= cfg_data_i[MASK_W-1:0];
        REG_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        REG_ICASE: icase_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n = (count_q > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS) : count_q;

  assign accept = in_valid_i && !in_stall_o;
  assign clr = accept && (func_e'(func_i) == FUNC_RESTART);
  // Once matched, consume transfers leave the states untouched.
  assign upd = accept && (func_e'(func_i) == FUNC_CONSUME) && (n != '0) && !match_q;

  assign link[0] = '0;

  for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
    snpm_atom_t atom;
    if (i < 8) begin : g_lo
      assign atom.lit = lit_lo_q[8*i +: 8];
    end else begin : g_hi
      assign atom.lit = lit_hi_q[8*(i-8) +: 8];
    end
    assign atom.any = any_q[i];
    assign atom.nonspace = nonspace_q[i];
    assign atom.rep = repeat_q[i];

    snpm_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .atom_i     (atom),
      .icase_i    (icase_q),
      .count_i    (n),
      .data_byte_i(data_byte_i),
      .upd_i      (upd),
      .clr_i      (clr),
      .link_i     (link[i]),
      .link_o     (link[i+1]),
      .acc_o      (acc[i]),
      .state_o    (state[i])
    );
  end

  // With a full-length pattern the accept state sits past the last cell.
  assign accept_hit = (|acc) || (link[MAX_ATOMS].nxt_carry && (n == CNT_W'(MAX_ATOMS)));

  always_comb begin
    match_d = match_q;
    if (clr) begin
      match_d = 1'b0;
    end else if (accept && (n == '0)) begin
      match_d = 1'b1;
    end else if (upd) begin
      match_d = accept_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign result = match_d || (n == '0);

  snpm_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .data_i     (result),
    .full_o     (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (matched_o),
    .out_stall_i(out_stall_i)
  );

  `SNPM_ASSERT_NEXT(a_restart_clears, clk_i, rst_ni, clr, (!match_q && (state == '0)), "restart did not clear the search state")
  `SNPM_ASSERT_NEXT(a_matched_frozen, clk_i, rst_ni, (match_q && !clr && !cfg_we_i), ($stable(state) && match_q), "state moved after a match")
  `SNPM_ASSERT_NEXT(a_empty_matches, clk_i, rst_ni, (accept && !clr && (n == '0)), match_q, "empty pattern did not latch a match")
  `SNPM_ASSERT_NOW(a_stall_needs_out, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with no result pending")

endmodule

/* src/snpm_cell.sv */
module snpm_cell import snpm_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  snpm_atom_t       atom_i,
  input  logic             icase_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [7:0]       data_byte_i,
  input  logic             upd_i,
  input  logic             clr_i,
  input  snpm_link_t       link_i,
  output snpm_link_t       link_o,
  output logic             acc_o,
  output logic             state_o
);

  localparam logic First = (IDX == 0);

  logic state_q, state_d;
  logic en, at_n, byte_hit, s, c, hit, hold, adv, d;

  assign en = count_i > CNT_W'(IDX);
  assign at_n = count_i == CNT_W'(IDX);

  always_comb begin
    if (atom_i.any) begin
      byte_hit = 1'b1;
    end else if (atom_i.nonspace) begin
      byte_hit = !is_blank(data_byte_i);
    end else if (icase_i) begin
      byte_hit = to_upper(data_byte_i) == to_upper(atom_i.lit);
    end else begin
      byte_hit = data_byte_i == atom_i.lit;
    end
  end

  // First closure ripples in from the left, then the byte test, then the
  // second closure ripples on through the advanced states.
  assign s = (state_q & en) | First;
  assign c = s | link_i.cur_carry;
  assign hit = c & en & byte_hit;
  assign hold = hit & atom_i.rep;
  assign adv = hit & ~atom_i.rep;
  assign d = hold | link_i.nxt_carry;

  assign link_o.cur_carry = c & atom_i.rep & en;
  assign link_o.nxt_carry = adv | (d & atom_i.rep & en);

  assign acc_o = d & at_n;
  assign state_o = state_q;

  always_comb begin
    state_d = state_q;
    if (clr_i) begin
      state_d = 1'b0;
    end else if (upd_i) begin
      state_d = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/snpm_obuf.sv */
module snpm_obuf (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic data_i,
  output logic full_o,
  output logic out_valid_o,
  output logic out_data_o,
  input  logic out_stall_i
);

  logic out_valid_q, out_valid_d;
  logic out_data_q, out_data_d;
  logic skid_valid_q, skid_valid_d;
  logic skid_data_q, skid_data_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // The skid entry takes a result only while the output register is held.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d = 1'b1;
        out_data_d = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule
